/* design/bps_pkg.sv */
// Shared types and constants for the buzzer pattern sequencer.
package bps_pkg;

   // Command codes carried on the request beat's tuser
   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_BEEP       = 3'd1,
      CMD_PATTERN    = 3'd2,
      CMD_RAPID      = 3'd3,
      CMD_SONAR_SET  = 3'd4,
      CMD_SONAR_STOP = 3'd5
   } cmd_type;

   // Pattern sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_CHIRP = 4'b0010,
      PH_PAUSE = 4'b0100,
      PH_MAIN  = 4'b1000
   } phase_type;

   // Phase codes as reported on the response beat
   localparam logic [1:0] PHASE_CODE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_CODE_CHIRP = 2'd1;
   localparam logic [1:0] PHASE_CODE_PAUSE = 2'd2;
   localparam logic [1:0] PHASE_CODE_MAIN  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_CHIRP_MS      = 2'd0;
   localparam logic [1:0] CSR_PAUSE_MS      = 2'd1;
   localparam logic [1:0] CSR_RAPID_HALF_MS = 2'd2;
   localparam logic [1:0] CSR_RAPID_COUNT   = 2'd3;

   localparam logic [15:0] CHIRP_MS_RESET      = 16'd20;
   localparam logic [15:0] PAUSE_MS_RESET      = 16'd60;
   localparam logic [15:0] RAPID_HALF_MS_RESET = 16'd20;
   localparam logic [7:0]  RAPID_COUNT_RESET   = 8'd3;
   localparam logic [15:0] SONAR_LENGTH_RESET  = 16'd30;

   typedef struct packed {
      logic [15:0] chirp_ms;
      logic [15:0] pause_ms;
      logic [15:0] rapid_half_ms;
      logic [7:0]  rapid_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] time_now;
      logic        pin_on;
      logic [31:0] simple_off_deadline;
      phase_type   phase;
      logic [31:0] phase_deadline;
      logic [15:0] main_length;
      logic        sonar_on;
      logic [31:0] sonar_spacing;
      logic [15:0] sonar_length;
      logic [31:0] sonar_next;
      logic [7:0]  burst_left;
      logic        burst_high;
      logic [31:0] burst_deadline;
   } state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] length_ticks;
      logic [31:0] spacing_ticks;
   } item_type;

endpackage

/* design/bps_update.sv */
// Next-state rule of the buzzer sequencer for one command beat.
module bps_update
   import bps_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type cur,
   input  item_type  item,
   output state_type nxt
);

   always_comb begin
      logic [31:0] now;
      logic [7:0]  left_dec;
      logic        phase_due;
      now      = cur.time_now + 32'd1;
      left_dec = cur.burst_left - 8'd1;
      nxt      = cur;
      phase_due = 1'b0;
      case (item.command)
         CMD_TICK: begin
            nxt.time_now = now;
            if (cur.burst_left != 8'd0) begin
               // burst owns the pin until it runs out
               if (now >= cur.burst_deadline) begin
                  if (cur.burst_high) begin
                     nxt.pin_on              = 1'b0;
                     nxt.simple_off_deadline = 32'd0;
                     nxt.burst_high          = 1'b0;
                     nxt.burst_left          = left_dec;
                     if (left_dec != 8'd0) begin
                        nxt.burst_deadline = now + {16'd0, cfg.rapid_half_ms};
                     end
                  end else begin
                     nxt.pin_on         = 1'b1;
                     nxt.burst_high     = 1'b1;
                     nxt.burst_deadline = now + {16'd0, cfg.rapid_half_ms};
                  end
               end
            end else begin
               if (cur.sonar_on && (cur.sonar_spacing != 32'd0) && (cur.phase == PH_IDLE) &&
                   (now >= cur.sonar_next)) begin
                  nxt.pin_on              = 1'b1;
                  nxt.simple_off_deadline = now + {16'd0, cur.sonar_length};
                  nxt.sonar_next          = now + cur.sonar_spacing;
               end
               phase_due = (cur.phase != PH_IDLE) && (now >= cur.phase_deadline);
               if (phase_due) begin
                  case (cur.phase)
                     PH_CHIRP: begin
                        nxt.pin_on              = 1'b0;
                        nxt.simple_off_deadline = 32'd0;
                        nxt.phase               = PH_PAUSE;
                        nxt.phase_deadline      = now + {16'd0, cfg.pause_ms};
                     end
                     PH_PAUSE: begin
                        nxt.pin_on         = 1'b1;
                        nxt.phase          = PH_MAIN;
                        nxt.phase_deadline = now + {16'd0, cur.main_length};
                     end
                     default: begin
                        nxt.pin_on              = 1'b0;
                        nxt.simple_off_deadline = 32'd0;
                        nxt.phase               = PH_IDLE;
                     end
                  endcase
               end else if ((nxt.simple_off_deadline != 32'd0) &&
                            (now >= nxt.simple_off_deadline)) begin
                  nxt.pin_on              = 1'b0;
                  nxt.simple_off_deadline = 32'd0;
               end
            end
         end
         CMD_BEEP: begin
            nxt.pin_on              = 1'b1;
            nxt.simple_off_deadline = cur.time_now + {16'd0, item.length_ticks};
         end
         CMD_PATTERN: begin
            nxt.phase               = PH_CHIRP;
            nxt.main_length         = item.length_ticks;
            nxt.phase_deadline      = cur.time_now + {16'd0, cfg.chirp_ms};
            nxt.simple_off_deadline = 32'd0;
            nxt.pin_on              = 1'b1;
         end
         CMD_RAPID: begin
            // ignore a request while a burst runs
            if (cur.burst_left == 8'd0) begin
               nxt.burst_left     = cfg.rapid_count;
               nxt.burst_high     = 1'b0;
               nxt.burst_deadline = 32'd0;
            end
         end
         CMD_SONAR_SET: begin
            if (item.spacing_ticks == 32'd0) begin
               nxt.sonar_on      = 1'b0;
               nxt.sonar_spacing = 32'd0;
               nxt.sonar_next    = 32'd0;
            end else begin
               nxt.sonar_spacing = item.spacing_ticks;
               nxt.sonar_length  = item.length_ticks;
               if (!cur.sonar_on) begin
                  nxt.sonar_on   = 1'b1;
                  nxt.sonar_next = cur.time_now;
               end
            end
         end
         CMD_SONAR_STOP: begin
            nxt.sonar_on      = 1'b0;
            nxt.sonar_spacing = 32'd0;
            nxt.sonar_next    = 32'd0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

/* design/buzzer_pattern_sequencer.sv */
// Top level of the buzzer pattern sequencer: handshakes, registers and state.
//
//   channel | dir | beat contents (lsb first)
//   --------+-----+------------------------------------------------------------
//   req_    | in  | tuser: command[2:0]
//           |     | tdata: length_ticks[15:0], spacing_ticks[47:16]
//   rsp_    | out | buzzer_level[0], sonar_running[1], pattern_phase[3:2],
//           |     | pulses_left[11:4], zero pad
//   csr_    | in  | csr_index selects chirp/pause/rapid_half/rapid_count
//
// Flow: a request beat lands in the input register, then the update logic
// writes the state and the response register; one beat per cycle while the
// response is not held. A 32-bit add and compare per deadline sets the cycle time.
// Reset: synchronous; clears the state and valids, restores register defaults.
// Stalls: rsp_tready low holds the response; the input register still takes
// one more beat, then req_tready drops until the response moves.
module buzzer_pattern_sequencer
   import bps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // command[2:0]
   input  logic [47:0] req_tdata,   // length_ticks[15:0], spacing_ticks[47:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // buzzer_level[0], sonar_running[1],
                                    // pattern_phase[3:2], pulses_left[11:4]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   item_type  item_ff;
   logic      item_valid_ff;
   logic      rsp_valid_ff;
   logic [11:0] rsp_data_ff;
   logic [11:0] rsp_data_in;
   logic      advance;
   logic      take;
   logic [1:0] phase_code;

   // the response slot frees when empty or taken this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign take       = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chirp_ms      <= CHIRP_MS_RESET;
         cfg_ff.pause_ms      <= PAUSE_MS_RESET;
         cfg_ff.rapid_half_ms <= RAPID_HALF_MS_RESET;
         cfg_ff.rapid_count   <= RAPID_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CHIRP_MS:      cfg_ff.chirp_ms      <= csr_data;
            CSR_PAUSE_MS:      cfg_ff.pause_ms      <= csr_data;
            CSR_RAPID_HALF_MS: cfg_ff.rapid_half_ms <= csr_data;
            CSR_RAPID_COUNT:   cfg_ff.rapid_count   <= csr_data[7:0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   // input register: valid under reset, payload loads on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.command       <= req_tuser;
         item_ff.length_ticks  <= req_tdata[15:0];
         item_ff.spacing_ticks <= req_tdata[47:16];
      end
   end

   bps_update u_update (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in)
   );

   // sequencer state: commit one command per taken beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.time_now            <= 32'd0;
         state_ff.pin_on              <= 1'b0;
         state_ff.simple_off_deadline <= 32'd0;
         state_ff.phase               <= PH_IDLE;
         state_ff.phase_deadline      <= 32'd0;
         state_ff.main_length         <= 16'd0;
         state_ff.sonar_on            <= 1'b0;
         state_ff.sonar_spacing       <= 32'd0;
         state_ff.sonar_length        <= SONAR_LENGTH_RESET;
         state_ff.sonar_next          <= 32'd0;
         state_ff.burst_left          <= 8'd0;
         state_ff.burst_high          <= 1'b0;
         state_ff.burst_deadline      <= 32'd0;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   // map the one-hot phase to its reported code
   always_comb begin
      case (state_in.phase)
         PH_IDLE:  phase_code = PHASE_CODE_IDLE;
         PH_CHIRP: phase_code = PHASE_CODE_CHIRP;
         PH_PAUSE: phase_code = PHASE_CODE_PAUSE;
         PH_MAIN:  phase_code = PHASE_CODE_MAIN;
         default:  phase_code = PHASE_CODE_IDLE;
      endcase
   end

   assign rsp_data_in = {state_in.burst_left, phase_code, state_in.sonar_on, state_in.pin_on};

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   // a high burst half always has pulses left to count
   a_burst_high: assert property (@(posedge clock) disable iff (reset)
      state_ff.burst_high |-> (state_ff.burst_left != 8'd0))
      else $error("burst high with no pulses left");

   // sonar mode and its spacing go on and off together
   a_sonar_spacing: assert property (@(posedge clock) disable iff (reset)
      state_ff.sonar_on == (state_ff.sonar_spacing != 32'd0))
      else $error("sonar flag and spacing disagree");

   // a committed command reports the pulse count it left behind
   a_rsp_pulses: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_tdata[11:4] == state_ff.burst_left))
      else $error("response pulse count differs from state");

   // the time counter moves only on a taken tick
   a_time_tick: assert property (@(posedge clock) disable iff (reset)
      (take && (item_ff.command != CMD_TICK)) |=> $stable(state_ff.time_now))
      else $error("time advanced without a tick");

endmodule

/* tb/tb_buzzer_pattern_sequencer.sv */
// Self-checking testbench for the buzzer pattern sequencer: driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_buzzer_pattern_sequencer;
   import bps_pkg::*;

   // Command codes the block must ignore
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD_AT = 400;   // response beat count that triggers the long hold
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int MAX_REPORTS = 20;

   // Pin, sonar flag, pattern phase code and pulse count, lsb first as on rsp_tdata
   typedef struct packed {
      logic [7:0] pulses_left;
      logic [1:0] pattern_phase;
      logic       sonar_running;
      logic       buzzer_level;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;   // command[2:0]
   logic [47:0] req_tdata = '0;   // length_ticks[15:0], spacing_ticks[47:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // buzzer_level[0], sonar_running[1],
                                  // pattern_phase[3:2], pulses_left[11:4]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   buzzer_pattern_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: settings plus a shadow copy of the sequencer state
   // ------------------------------------------------------------------
   cfg_type     bz_cfg;
   logic [31:0] bz_time;
   logic        bz_pin;
   logic [31:0] bz_off_deadline;     // zero means no simple-beep deadline
   logic [1:0]  bz_phase;
   logic [31:0] bz_phase_deadline;
   logic [15:0] bz_main_len;
   logic        bz_sonar_on;
   logic [31:0] bz_sonar_gap;
   logic [15:0] bz_sonar_len;
   logic [31:0] bz_sonar_next;
   logic [7:0]  bz_burst_left;
   logic        bz_burst_high;
   logic [31:0] bz_burst_deadline;

   item_type     pending_items[$];    // beats still to be offered
   reading_type  expected_readings[$];
   item_type     cur_item;

   bit idle_on = 1'b1;              // random idling on both sides
   int req_gap = 0;
   int rsp_stall = 0;
   bit long_hold_done = 1'b0;
   int cycle_count = 0;
   int errors = 0;
   int req_beats = 0;
   int cmd_beats = 0;
   int rsp_beats = 0;
   int settings_done = 0;

   // Advance the shadow state by one request beat and return the reading it leaves.
   function automatic reading_type advance_buzzer(input item_type it);
      logic [31:0] now;
      reading_type r;
      case (it.command)
         CMD_TICK: begin
            bz_time = bz_time + 32'd1;
            now = bz_time;
            if (bz_burst_left != 0) begin
               // burst owns the pin: toggle at each half-period deadline
               if (now >= bz_burst_deadline) begin
                  if (bz_burst_high) begin
                     bz_pin = 1'b0;
                     bz_off_deadline = '0;
                     bz_burst_high = 1'b0;
                     bz_burst_left = bz_burst_left - 8'd1;
                     if (bz_burst_left != 0)
                        bz_burst_deadline = now + {16'd0, bz_cfg.rapid_half_ms};
                  end else begin
                     bz_pin = 1'b1;
                     bz_burst_high = 1'b1;
                     bz_burst_deadline = now + {16'd0, bz_cfg.rapid_half_ms};
                  end
               end
            end else begin
               // sonar fires only while the pattern is idle
               if (bz_sonar_on && bz_sonar_gap != 0 && bz_phase == PHASE_CODE_IDLE &&
                   now >= bz_sonar_next) begin
                  bz_pin = 1'b1;
                  bz_off_deadline = now + {16'd0, bz_sonar_len};
                  bz_sonar_next = now + bz_sonar_gap;
               end
               if (bz_phase != PHASE_CODE_IDLE && now >= bz_phase_deadline) begin
                  case (bz_phase)
                     PHASE_CODE_CHIRP: begin
                        bz_pin = 1'b0;
                        bz_off_deadline = '0;
                        bz_phase = PHASE_CODE_PAUSE;
                        bz_phase_deadline = now + {16'd0, bz_cfg.pause_ms};
                     end
                     PHASE_CODE_PAUSE: begin
                        bz_pin = 1'b1;
                        bz_phase = PHASE_CODE_MAIN;
                        bz_phase_deadline = now + {16'd0, bz_main_len};
                     end
                     default: begin
                        bz_pin = 1'b0;
                        bz_off_deadline = '0;
                        bz_phase = PHASE_CODE_IDLE;
                     end
                  endcase
               end else if (bz_off_deadline != 0 && now >= bz_off_deadline) begin
                  bz_pin = 1'b0;
                  bz_off_deadline = '0;
               end
            end
         end
         CMD_BEEP: begin
            bz_pin = 1'b1;
            bz_off_deadline = bz_time + {16'd0, it.length_ticks};
         end
         CMD_PATTERN: begin
            bz_phase = PHASE_CODE_CHIRP;
            bz_main_len = it.length_ticks;
            bz_phase_deadline = bz_time + {16'd0, bz_cfg.chirp_ms};
            bz_off_deadline = '0;
            bz_pin = 1'b1;
         end
         CMD_RAPID: begin
            // a request during a running burst is dropped
            if (bz_burst_left == 0) begin
               bz_burst_left = bz_cfg.rapid_count;
               bz_burst_high = 1'b0;
               bz_burst_deadline = '0;
            end
         end
         CMD_SONAR_SET: begin
            if (it.spacing_ticks == 0) begin
               bz_sonar_on = 1'b0;
               bz_sonar_gap = '0;
               bz_sonar_next = '0;
            end else begin
               bz_sonar_gap = it.spacing_ticks;
               bz_sonar_len = it.length_ticks;
               if (!bz_sonar_on) begin
                  bz_sonar_on = 1'b1;
                  bz_sonar_next = bz_time;
               end
            end
         end
         CMD_SONAR_STOP: begin
            bz_sonar_on = 1'b0;
            bz_sonar_gap = '0;
            bz_sonar_next = '0;
         end
         default: ;   // spare codes leave everything as it is
      endcase
      r.buzzer_level = bz_pin;
      r.sonar_running = bz_sonar_on;
      r.pattern_phase = bz_phase;
      r.pulses_left = bz_burst_left;
      return r;
   endfunction

   function automatic void queue_item(input logic [2:0] cmd, input logic [15:0] dur,
                                      input logic [31:0] ivl);
      item_type it;
      it.command = cmd;
      it.length_ticks = dur;
      it.spacing_ticks = ivl;
      pending_items.push_back(it);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Write one register through the CSR channel; update the shadow settings on the beat.
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CHIRP_MS:      bz_cfg.chirp_ms = val;
         CSR_PAUSE_MS:      bz_cfg.pause_ms = val;
         CSR_RAPID_HALF_MS: bz_cfg.rapid_half_ms = val;
         CSR_RAPID_COUNT:   bz_cfg.rapid_count = val[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [15:0] chirp, input logic [15:0] pause,
                                input logic [15:0] half, input logic [7:0] count);
      write_reg(CSR_CHIRP_MS, chirp);
      write_reg(CSR_PAUSE_MS, pause);
      write_reg(CSR_RAPID_HALF_MS, half);
      write_reg(CSR_RAPID_COUNT, {8'd0, count});
      settings_done++;
   endtask

   // Hold until every queued beat has gone in and every reading has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_readings.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Queue about n meaningful beats: each a command followed by a run of ticks,
   // so patterns, bursts and sonar beeps get time to play out.
   task automatic queue_random(input int n);
      int queued;
      int pick;
      int run;
      logic [2:0] cmd;
      logic [15:0] dur;
      logic [31:0] ivl;
      queued = 0;
      while (queued < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) cmd = CMD_BEEP;
         else if (pick < 44) cmd = CMD_PATTERN;
         else if (pick < 62) cmd = CMD_RAPID;
         else if (pick < 80) cmd = CMD_SONAR_SET;
         else if (pick < 92) cmd = CMD_SONAR_STOP;
         else cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;

         pick = $urandom_range(0, 9);
         if (pick < 7) dur = 16'($urandom_range(0, 40));
         else if (pick < 9) dur = 16'($urandom_range(0, 300));
         else dur = 16'($urandom);

         pick = $urandom_range(0, 9);
         if (pick == 0) ivl = '0;
         else if (pick < 7) ivl = $urandom_range(1, 60);
         else if (pick < 9) ivl = $urandom_range(61, 500);
         else ivl = $urandom;

         queue_item(cmd, dur, ivl);
         if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI)
            queued++;

         pick = $urandom_range(0, 9);
         if (pick < 6) run = $urandom_range(0, 8);
         else if (pick < 9) run = $urandom_range(9, 60);
         else run = $urandom_range(61, 200);
         // tick fields are don't-care; fill them with noise
         repeat (run) queue_item(CMD_TICK, 16'($urandom), $urandom);
         queued += run;
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver: offer beats from pending_items, predict on each beat
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(advance_buzzer(cur_item));
            req_beats++;
            if (cur_item.command != CMD_TICK)
               cmd_beats++;
         end
         // the slot is free once the current beat went or none was offered
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               req_gap <= $urandom_range(0, 7);
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_item.command;
               req_tdata <= {cur_item.spacing_ticks, cur_item.length_ticks};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: compare each beat with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      reading_type want;
      reading_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            got = rsp_tdata[11:0];
            if (expected_readings.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected response beat, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = expected_readings.pop_front();
               check_field("buzzer_level", 32'(want.buzzer_level), 32'(got.buzzer_level));
               check_field("sonar_running", 32'(want.sonar_running),
                           32'(got.sonar_running));
               check_field("pattern_phase", 32'(want.pattern_phase),
                           32'(got.pattern_phase));
               check_field("pulses_left", 32'(want.pulses_left), 32'(got.pulses_left));
               check_field("pad bits", 0, 32'(rsp_tdata[15:12]));
            end
         end
         // once in the run, hold off long enough that the block backs up
         if (!long_hold_done && rsp_beats >= LONG_HOLD_AT && req_tvalid) begin
            long_hold_done <= 1'b1;
            rsp_stall <= LONG_HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, expected_readings.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, directed beats, then random phases under several settings
   // ------------------------------------------------------------------
   initial begin
      bz_cfg.chirp_ms = CHIRP_MS_RESET;
      bz_cfg.pause_ms = PAUSE_MS_RESET;
      bz_cfg.rapid_half_ms = RAPID_HALF_MS_RESET;
      bz_cfg.rapid_count = RAPID_COUNT_RESET;
      bz_time = '0;
      bz_pin = 1'b0;
      bz_off_deadline = '0;
      bz_phase = PHASE_CODE_IDLE;
      bz_phase_deadline = '0;
      bz_main_len = '0;
      bz_sonar_on = 1'b0;
      bz_sonar_gap = '0;
      bz_sonar_len = SONAR_LENGTH_RESET;
      bz_sonar_next = '0;
      bz_burst_left = '0;
      bz_burst_high = 1'b0;
      bz_burst_deadline = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at reset settings: field extremes, every command,
      // spare codes, zero-interval sonar set, sonar update while running,
      // zero-length beep and a second burst request during a burst.
      // A beep deadline that wraps to zero needs the time counter near its
      // top, which no run of ticks here can reach.
      queue_item(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_BEEP, 16'd0, 32'd0);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_BEEP, 16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_SONAR_SET, 16'd7, 32'd0);
      queue_item(CMD_SONAR_SET, 16'd2, 32'd3);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_SONAR_SET, 16'd1, 32'hFFFF_FFFF);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_SONAR_STOP, 16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_PATTERN, 16'hFFFF, 32'd0);
      queue_item(CMD_RAPID, 16'd0, 32'd0);
      queue_item(CMD_RAPID, 16'd0, 32'd0);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_item(CMD_PATTERN, 16'd0, 32'd0);
      repeat (3) queue_item(CMD_TICK, 16'd0, 32'd0);
      queue_random(280);
      wait_drained();

      load_settings(16'd5, 16'd10, 16'd3, 8'd2);
      queue_random(320);
      wait_drained();

      // zero lengths everywhere, single-pulse bursts
      load_settings(16'd0, 16'd0, 16'd0, 8'd1);
      queue_random(320);
      wait_drained();

      // top of every range; patterns and bursts stay put, so keep it short
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
      queue_random(60);
      wait_drained();

      // burst count of zero turns rapid requests into no-ops
      load_settings(16'd1, 16'd1, 16'd1, 8'd0);
      queue_random(320);
      wait_drained();

      load_settings(16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                    16'($urandom_range(0, 10)), 8'($urandom_range(1, 6)));
      queue_random(320);
      wait_drained();

      // last stretch at reset values with both sides streaming flat out
      idle_on = 1'b0;
      load_settings(CHIRP_MS_RESET, PAUSE_MS_RESET, RAPID_HALF_MS_RESET, RAPID_COUNT_RESET);
      queue_random(200);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d request beats (%0d commands, rest ticks) and %0d response beats",
               req_beats, cmd_beats, rsp_beats);
      $display("across %0d register settings plus reset values, %0d mismatches",
               settings_done, errors);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
design/bps_pkg.sv
design/bps_update.sv
design/buzzer_pattern_sequencer.sv
tb/tb_buzzer_pattern_sequencer.sv
